// ----- rtl/length_prefixed_deframer_defines.svh -----
// ---------------------------------------------------------------------------
// Length-prefixed deframer assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during rst.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define LPD_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpd assertion failed");

// next-cycle implication
`define LPD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpd assertion failed");

`endif

// ----- rtl/lpd_pkg.sv -----
// ---------------------------------------------------------------------------
// Length-prefixed deframer package
// Widths, register codes, beat and result types, header size clamp.
// ---------------------------------------------------------------------------
package lpd_pkg;

  localparam int LengthBits = 16;
  localparam int MaxHeader  = 16;

  localparam int ByteW   = 8;
  localparam int TagW    = 16;
  localparam int HdrW    = 5;
  localparam int OffW    = 17;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_SIZE = 2'd0,
    REG_MAX_PAYLOAD = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [HdrW-1:0]       header_size;
    logic [LengthBits-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [TagW-1:0]  source_tag;
  } in_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             frame_first;
    logic             frame_last;
    logic [OffW-1:0]  frame_offset;
    logic [OffW-1:0]  frame_total;
    logic             too_long;
    logic [TagW-1:0]  out_tag;
  } res_t;

  function automatic logic [HdrW-1:0] eff_header(input logic [HdrW-1:0] h);
    logic [HdrW-1:0] r;
    r = h;
    if (h < HdrW'(2)) r = HdrW'(2);
    else if (int'(h) > MaxHeader) r = HdrW'(MaxHeader);
    return r;
  endfunction

endpackage

// ----- rtl/lpd_if.sv -----
// ---------------------------------------------------------------------------
// Length-prefixed deframer channels
// Valid/ready channels for received bytes and tagged result bytes.
// ---------------------------------------------------------------------------
interface lpd_in_if;
  logic                       valid;
  logic                       ready;
  logic [lpd_pkg::ByteW-1:0]  data_byte;
  logic                       chunk_last;
  logic [lpd_pkg::TagW-1:0]   source_tag;

  modport source (output valid, data_byte, chunk_last, source_tag, input ready);
  modport sink (input valid, data_byte, chunk_last, source_tag, output ready);
endinterface

interface lpd_out_if;
  logic                       valid;
  logic                       ready;
  logic [lpd_pkg::ByteW-1:0]  out_byte;
  logic                       frame_first;
  logic                       frame_last;
  logic [lpd_pkg::OffW-1:0]   frame_offset;
  logic [lpd_pkg::OffW-1:0]   frame_total;
  logic                       too_long;
  logic [lpd_pkg::TagW-1:0]   out_tag;

  modport source (output valid, out_byte, frame_first, frame_last, frame_offset,
                  frame_total, too_long, out_tag, input ready);
  modport sink (input valid, out_byte, frame_first, frame_last, frame_offset,
                frame_total, too_long, out_tag, output ready);
endinterface

// ----- rtl/lpd_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// Length-prefixed deframer configuration registers
// Header size and payload limit, written through a plain write port.
// ---------------------------------------------------------------------------
module lpd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [lpd_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [lpd_pkg::CfgDataW-1:0]  wr_data,
  output lpd_pkg::cfg_t                 cfg
);
  import lpd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_size <= HdrW'(4);
      cfg.max_payload <= LengthBits'(2048);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HEADER_SIZE: cfg.header_size <= wr_data[HdrW-1:0];
        REG_MAX_PAYLOAD: cfg.max_payload <= wr_data[LengthBits-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/lpd_frame_track.sv -----
// ---------------------------------------------------------------------------
// Length-prefixed deframer frame tracker
// Holds the frame offset and length, tags one beat per step.
// ---------------------------------------------------------------------------
module lpd_frame_track (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  lpd_pkg::in_beat_t beat,
  input  lpd_pkg::cfg_t     cfg,
  output lpd_pkg::res_t     res
);
  import lpd_pkg::*;

  logic [OffW-1:0]       offset;
  logic [LengthBits-1:0] plen;
  logic                  known;

  logic [OffW-1:0]       offset_next;
  logic [LengthBits-1:0] plen_next;
  logic                  known_next;
  logic                  at_first;
  logic                  at_second;
  logic [OffW-1:0]       total;
  logic [OffW:0]         off_inc;
  logic                  last;

  always_comb begin
    at_first  = (offset == '0);
    at_second = (offset == OffW'(1)) && !known;
    off_inc   = {1'b0, offset} + (OffW+1)'(1);

    plen_next  = plen;
    known_next = known;
    if (at_first) begin
      plen_next  = LengthBits'(beat.data_byte);
      known_next = 1'b0;
    end else if (at_second) begin
      plen_next  = plen | LengthBits'({beat.data_byte, 8'h00});
      known_next = 1'b1;
    end

    total = '0;
    last  = 1'b0;
    if (known_next) begin
      total = OffW'(eff_header(cfg.header_size)) + OffW'(plen_next);
      last  = off_inc >= {1'b0, total};
    end

    res.out_byte     = beat.data_byte;
    res.frame_first  = at_first;
    res.frame_last   = last;
    res.frame_offset = offset;
    res.frame_total  = total;
    res.too_long     = known_next && (plen_next > cfg.max_payload);
    res.out_tag      = beat.source_tag;

    offset_next = last ? '0 : off_inc[OffW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      plen   <= '0;
      known  <= 1'b0;
    end else if (step) begin
      offset <= offset_next;
      plen   <= last ? '0 : plen_next;
      known  <= last ? 1'b0 : known_next;
    end
  end

endmodule

// ----- rtl/length_prefixed_deframer.sv -----
// ---------------------------------------------------------------------------
// Length-prefixed deframer
// Cuts a byte stream into length-prefixed frames and tags every byte.
// ---------------------------------------------------------------------------
// One byte in, one tagged byte out, at one beat per cycle while the
// receiver keeps ready high: an input register feeds the frame tracker and an
// output register holds the result. The first two header bytes carry the
// payload length, low byte first; frame_total and too_long are zero on the
// first header byte. Header-only frames end on the last header byte.
// Write configuration only while no beats are in flight.
// ---------------------------------------------------------------------------
`include "length_prefixed_deframer_defines.svh"

module length_prefixed_deframer (
  input  logic                          clk,
  input  logic                          rst,
  lpd_in_if.sink                        in_ch,
  lpd_out_if.source                     out_ch,
  input  logic                          wr_en,
  input  logic [lpd_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [lpd_pkg::CfgDataW-1:0]  wr_data
);
  import lpd_pkg::*;

  cfg_t     cfg;
  in_beat_t in_beat;
  logic     in_valid;
  res_t     res;
  res_t     out_res;
  logic     out_valid;
  logic     adv;

  lpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  assign adv         = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_beat.data_byte  <= in_ch.data_byte;
      in_beat.source_tag <= in_ch.source_tag;
    end
  end

  lpd_frame_track u_track (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .beat (in_beat),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.out_byte     = out_res.out_byte;
  assign out_ch.frame_first  = out_res.frame_first;
  assign out_ch.frame_last   = out_res.frame_last;
  assign out_ch.frame_offset = out_res.frame_offset;
  assign out_ch.frame_total  = out_res.frame_total;
  assign out_ch.too_long     = out_res.too_long;
  assign out_ch.out_tag      = out_res.out_tag;

  `LPD_ASSERT_NOW(a_first_no_len, clk, rst, out_valid && out_res.frame_first, out_res.frame_total == '0 && !out_res.too_long)
  `LPD_ASSERT_NOW(a_last_has_len, clk, rst, out_valid && out_res.frame_last, out_res.frame_total != '0)
  `LPD_ASSERT_NOW(a_len_after_hdr, clk, rst, out_valid && out_res.frame_offset > OffW'(1), out_res.frame_total != '0)
  `LPD_ASSERT_NEXT(a_out_held, clk, rst, out_valid && !out_ch.ready, out_valid && $stable(out_res))

endmodule

// ----- test/tb_top.sv -----
// ---------------------------------------------------------------------------
// Length-prefixed deframer testbench
// Drives a byte stream of length-prefixed frames through the deframer and checks every
// tagged output beat against the expected result of a typed directed beat, else against
// a cycle-free frame tracker kept here. A short table of directed beats comes first,
// then random frames under several header sizes, length limits and handshake pressures.
// ---------------------------------------------------------------------------
module tb_top;
  import lpd_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd2;

  typedef enum {ROW_BEAT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] wdata;
    logic [ByteW-1:0]    b;
    logic                cl;
    logic [TagW-1:0]     tag;
    bit                  typed;
    res_t                res;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [CfgIdxW-1:0] wr_index;
  logic [CfgDataW-1:0] wr_data;

  lpd_in_if in_ch ();
  lpd_out_if out_ch ();

  length_prefixed_deframer dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always #1 clk = ~clk;

  // frame tracker state and register copies
  logic [HdrW-1:0]       hdr_reg = HdrW'(4);
  logic [LengthBits-1:0] len_limit = LengthBits'(2048);
  logic [OffW-1:0]       pos_in_frame = '0;
  logic [LengthBits-1:0] len_acc = '0;
  bit                    len_valid = 1'b0;

  res_t tagged_beat_q[$];
  row_t dir_rows[$];
  int unsigned mismatch_cnt = 0;
  int unsigned beats_seen = 0;
  int unsigned cyc = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_start = 1'b0;
  int unsigned hold_left = 0;

  function automatic int unsigned header_bytes();
    if (hdr_reg < 2) return 2;
    if (hdr_reg > MaxHeader) return MaxHeader;
    return hdr_reg;
  endfunction

  function automatic res_t deframe_byte(input logic [ByteW-1:0] b,
                                        input logic [TagW-1:0] tag);
    res_t r;
    int unsigned total;
    r = '0;
    r.out_byte = b;
    r.out_tag = tag;
    r.frame_offset = pos_in_frame;
    r.frame_first = (pos_in_frame == 0);
    if (pos_in_frame == 0) begin
      len_acc = {8'h00, b};
      len_valid = 1'b0;
    end else if (pos_in_frame == 1 && !len_valid) begin
      len_acc = {b, len_acc[7:0]};
      len_valid = 1'b1;
    end
    if (len_valid) begin
      total = header_bytes() + len_acc;
      r.frame_total = total[OffW-1:0];
      r.too_long = (len_acc > len_limit);
      r.frame_last = (int'(pos_in_frame) + 1 >= total);
    end
    if (r.frame_last) begin
      pos_in_frame = '0;
      len_acc = '0;
      len_valid = 1'b0;
    end else begin
      pos_in_frame = pos_in_frame + 1'b1;
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_cnt++;
    $display("ERROR: %s", msg);
  endtask

  task automatic push_byte(input logic [ByteW-1:0] b, input logic cl,
                           input logic [TagW-1:0] tag, input bit typed,
                           input res_t res);
    res_t p;
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.chunk_last <= cl;
    in_ch.source_tag <= tag;
    do @(posedge clk); while (!in_ch.ready);
    p = deframe_byte(b, tag);
    tagged_beat_q.push_back(typed ? res : p);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    in_ch.valid <= 1'b0;
    while (tagged_beat_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    if (idx == REG_HEADER_SIZE) hdr_reg = data[HdrW-1:0];
    else if (idx == REG_MAX_PAYLOAD) len_limit = data;
    wr_en <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned plen);
    int unsigned n;
    logic [ByteW-1:0] b;
    n = header_bytes() + plen;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0) b = plen[7:0];
      else if (i == 1) b = plen[15:8];
      else b = ByteW'($urandom_range(255));
      push_byte(b, 1'($urandom_range(1)), TagW'($urandom_range(65535)), 1'b0, '0);
    end
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 0;
    if (r < 75) return $urandom_range(12, 1);
    if (r < 95) return $urandom_range(40, 13);
    return $urandom_range(300, 256);
  endfunction

  task automatic run_phase(input logic [CfgDataW-1:0] hdr_data,
                           input logic [CfgDataW-1:0] max_data,
                           input int idle, input int stall, input bit hold,
                           input int unsigned nbytes);
    int unsigned sent;
    int unsigned plen;
    write_reg(REG_HEADER_SIZE, hdr_data);
    write_reg(REG_MAX_PAYLOAD, max_data);
    idle_pct = idle;
    stall_pct = stall;
    if (hold) hold_start <= 1'b1;
    sent = 0;
    while (sent < nbytes) begin
      plen = pick_len();
      send_frame(plen);
      sent += header_bytes() + plen;
    end
  endtask

  task automatic row_beat(input logic [ByteW-1:0] b, input logic cl,
                          input logic [TagW-1:0] tag, input bit typed,
                          input res_t res);
    dir_rows.push_back('{ROW_BEAT, '0, '0, b, cl, tag, typed, res});
  endtask

  task automatic row_write(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    dir_rows.push_back('{ROW_WRITE, idx, data, '0, 1'b0, '0, 1'b0, '0});
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_start) begin
      out_ch.ready <= 1'b0;
      hold_left <= 300;
      hold_start <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    res_t got;
    res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_byte, out_ch.frame_first, out_ch.frame_last,
              out_ch.frame_offset, out_ch.frame_total, out_ch.too_long,
              out_ch.out_tag};
      if (tagged_beat_q.size() == 0) begin
        flag_error($sformatf("beat %0d arrived with nothing expected", beats_seen));
      end else begin
        e = tagged_beat_q.pop_front();
        if (got.out_byte !== e.out_byte)
          flag_error($sformatf("beat %0d out_byte %0h exp %0h", beats_seen,
                               got.out_byte, e.out_byte));
        if (got.frame_first !== e.frame_first)
          flag_error($sformatf("beat %0d frame_first %0b exp %0b", beats_seen,
                               got.frame_first, e.frame_first));
        if (got.frame_last !== e.frame_last)
          flag_error($sformatf("beat %0d frame_last %0b exp %0b", beats_seen,
                               got.frame_last, e.frame_last));
        if (got.frame_offset !== e.frame_offset)
          flag_error($sformatf("beat %0d frame_offset %0d exp %0d", beats_seen,
                               got.frame_offset, e.frame_offset));
        if (got.frame_total !== e.frame_total)
          flag_error($sformatf("beat %0d frame_total %0d exp %0d", beats_seen,
                               got.frame_total, e.frame_total));
        if (got.too_long !== e.too_long)
          flag_error($sformatf("beat %0d too_long %0b exp %0b", beats_seen,
                               got.too_long, e.too_long));
        if (got.out_tag !== e.out_tag)
          flag_error($sformatf("beat %0d out_tag %0h exp %0h", beats_seen,
                               got.out_tag, e.out_tag));
      end
      beats_seen++;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.chunk_last = 1'b0;
    in_ch.source_tag = '0;
    out_ch.ready = 1'b0;
    wr_en = 1'b0;
    wr_index = REG_HEADER_SIZE;
    wr_data = '0;

    // reset config: header 4, limit 2048; empty payload ends on last header byte
    row_beat(8'h00, 1'b0, 16'h0000, 1'b1, '{8'h00, 1'b1, 1'b0, 17'd0, 17'd0, 1'b0, 16'h0000});
    row_beat(8'h00, 1'b1, 16'hFFFF, 1'b1, '{8'h00, 1'b0, 1'b0, 17'd1, 17'd4, 1'b0, 16'hFFFF});
    row_beat(8'hFF, 1'b0, 16'h0001, 1'b1, '{8'hFF, 1'b0, 1'b0, 17'd2, 17'd4, 1'b0, 16'h0001});
    row_beat(8'h55, 1'b1, 16'h8000, 1'b1, '{8'h55, 1'b0, 1'b1, 17'd3, 17'd4, 1'b0, 16'h8000});
    // limit 0: one-byte payload flagged, still counted out
    row_write(REG_MAX_PAYLOAD, 16'h0000);
    row_beat(8'h01, 1'b0, 16'h1234, 1'b1, '{8'h01, 1'b1, 1'b0, 17'd0, 17'd0, 1'b0, 16'h1234});
    row_beat(8'h00, 1'b0, 16'h5678, 1'b1, '{8'h00, 1'b0, 1'b0, 17'd1, 17'd5, 1'b1, 16'h5678});
    row_beat(8'hAA, 1'b1, 16'h9ABC, 1'b1, '{8'hAA, 1'b0, 1'b0, 17'd2, 17'd5, 1'b1, 16'h9ABC});
    row_beat(8'h80, 1'b0, 16'hDEF0, 1'b1, '{8'h80, 1'b0, 1'b0, 17'd3, 17'd5, 1'b1, 16'hDEF0});
    row_beat(8'h7F, 1'b1, 16'h0F0F, 1'b1, '{8'h7F, 1'b0, 1'b1, 17'd4, 17'd5, 1'b1, 16'h0F0F});
    // header size 1 (upper data bits dropped) clamps to 2
    row_write(REG_HEADER_SIZE, 16'hFFE1);
    row_beat(8'h00, 1'b0, 16'hF0F0, 1'b1, '{8'h00, 1'b1, 1'b0, 17'd0, 17'd0, 1'b0, 16'hF0F0});
    row_beat(8'h00, 1'b1, 16'h00FF, 1'b1, '{8'h00, 1'b0, 1'b1, 17'd1, 17'd2, 1'b0, 16'h00FF});
    // write to an unused index changes nothing
    row_write(REG_SPARE, 16'h0010);
    row_beat(8'h02, 1'b0, 16'hFF00, 1'b1, '{8'h02, 1'b1, 1'b0, 17'd0, 17'd0, 1'b0, 16'hFF00});
    row_beat(8'h00, 1'b0, 16'hAAAA, 1'b1, '{8'h00, 1'b0, 1'b0, 17'd1, 17'd4, 1'b1, 16'hAAAA});
    row_beat(8'hC3, 1'b1, 16'h5555, 1'b1, '{8'hC3, 1'b0, 1'b0, 17'd2, 17'd4, 1'b1, 16'h5555});
    row_beat(8'h3C, 1'b0, 16'h7FFF, 1'b1, '{8'h3C, 1'b0, 1'b1, 17'd3, 17'd4, 1'b1, 16'h7FFF});
    row_write(REG_MAX_PAYLOAD, 16'hFFFF);
    row_write(REG_HEADER_SIZE, 16'h0003);
    row_beat(8'h03, 1'b1, 16'h1357, 1'b0, '0);
    row_beat(8'h00, 1'b0, 16'h2468, 1'b0, '0);
    row_beat(8'h5A, 1'b1, 16'hCAFE, 1'b0, '0);
    row_beat(8'hFE, 1'b0, 16'h0BAD, 1'b0, '0);
    row_beat(8'h01, 1'b1, 16'hBEEF, 1'b0, '0);
    row_beat(8'hEF, 1'b0, 16'hFACE, 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_reg(dir_rows[i].idx, dir_rows[i].wdata);
      end else begin
        push_byte(dir_rows[i].b, dir_rows[i].cl, dir_rows[i].tag, dir_rows[i].typed,
                  dir_rows[i].res);
      end
    end

    run_phase(16'h0002, 16'hFFFF, 0, 0, 1'b0, 100);
    run_phase(16'h0010, 16'h0000, 48, 0, 1'b0, 100);
    run_phase(16'h0000, 16'h0007, 0, 48, 1'b1, 100);
    run_phase(16'h001F, 16'h0003, 24, 24, 1'b0, 100);
    run_phase(16'hFFE5, 16'h0800, 24, 24, 1'b0, 100);
    run_phase(16'h0009, 16'h000C, 0, 0, 1'b0, 60);

    in_ch.valid <= 1'b0;
    while (tagged_beat_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
